// ----- design/r2h_pkg.sv -----
// Shared constants and types for the RGB to HSV converter.
package r2h_pkg;

  // The hue divisor is six times delta, which needs three bits above a channel.
  localparam int unsigned DIV_EXTRA_BITS = 3;

  // Which channel holds the maximum; red wins ties, then green.
  typedef enum logic [2:0] {
    MAX_RED   = 3'b001,
    MAX_GREEN = 3'b010,
    MAX_BLUE  = 3'b100
  } r2h_max_e;

endpackage

// ----- design/r2h_if.sv -----
// Handshake interfaces for the pixel input and the HSV result channels.
interface r2h_pix_if #(
  parameter int unsigned CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface r2h_hsv_if #(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned HUE_BITS     = 16
);
  logic                    valid;
  logic                    ready;
  logic [HUE_BITS-1:0]     hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// ----- design/rgb_to_hsv_top.sv -----
// Top level of the RGB to HSV converter: front stage and divider cell chain.
//
// Usage: pixels enter on pix_i (red, green, blue, CHANNEL_BITS each) with a
// valid/ready handshake; one HSV item leaves on hsv_o for every pixel, in order.
// Brightness is the largest channel, saturation is floor(max_code*delta/max),
// and hue is a HUE_BITS fraction of a full turn. Gray pixels give zero hue and
// saturation.
// Throughput is one item per clock while hsv_o is not stalled. The front
// register takes the item at the accepting edge, and each following cell adds
// one register, one cell per quotient bit of the longer of the two restoring
// divisions, which run side by side down the chain.
// Each stage holds its own valid bit and moves when the stage after it is
// empty or moving, so a stall at hsv_o fills bubbles before pix_i.ready drops.
// A result held on hsv_o stays stable until taken.
// Reset clears all valid bits; no item is in flight afterwards.
module rgb_to_hsv_top
  import r2h_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned HUE_BITS     = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  r2h_pix_if.sink   pix_i,
  r2h_hsv_if.source hsv_o
);

  localparam int unsigned C      = CHANNEL_BITS;
  localparam int unsigned DW     = CHANNEL_BITS + DIV_EXTRA_BITS;
  localparam int unsigned STAGES = (CHANNEL_BITS > HUE_BITS) ? CHANNEL_BITS : HUE_BITS;

  logic                valid  [0:STAGES];
  logic                ready  [0:STAGES];
  logic                gray   [0:STAGES];
  logic [C-1:0]        bright [0:STAGES];
  logic [DW-1:0]       h_rem  [0:STAGES];
  logic [DW-1:0]       h_div  [0:STAGES];
  logic [HUE_BITS-1:0] h_quo  [0:STAGES];
  logic [C-1:0]        s_rem  [0:STAGES];
  logic [C-1:0]        s_low  [0:STAGES];
  logic [C-1:0]        s_quo  [0:STAGES];

  r2h_front #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .HUE_BITS     (HUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .red_i       (pix_i.red),
    .green_i     (pix_i.green),
    .blue_i      (pix_i.blue),
    .out_valid_o (valid[0]),
    .out_ready_i (ready[0]),
    .gray_o      (gray[0]),
    .bright_o    (bright[0]),
    .hue_rem_o   (h_rem[0]),
    .hue_div_o   (h_div[0]),
    .hue_quo_o   (h_quo[0]),
    .sat_rem_o   (s_rem[0]),
    .sat_low_o   (s_low[0]),
    .sat_quo_o   (s_quo[0])
  );

  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    r2h_div_cell #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .HUE_BITS     (HUE_BITS),
      .DO_HUE       (k < HUE_BITS),
      .DO_SAT       (k < CHANNEL_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[k]),
      .in_ready_o  (ready[k]),
      .out_valid_o (valid[k+1]),
      .out_ready_i (ready[k+1]),
      .gray_i      (gray[k]),
      .bright_i    (bright[k]),
      .hue_rem_i   (h_rem[k]),
      .hue_div_i   (h_div[k]),
      .hue_quo_i   (h_quo[k]),
      .sat_rem_i   (s_rem[k]),
      .sat_low_i   (s_low[k]),
      .sat_quo_i   (s_quo[k]),
      .gray_o      (gray[k+1]),
      .bright_o    (bright[k+1]),
      .hue_rem_o   (h_rem[k+1]),
      .hue_div_o   (h_div[k+1]),
      .hue_quo_o   (h_quo[k+1]),
      .sat_rem_o   (s_rem[k+1]),
      .sat_low_o   (s_low[k+1]),
      .sat_quo_o   (s_quo[k+1])
    );
  end

  assign ready[STAGES]    = hsv_o.ready;
  assign hsv_o.valid      = valid[STAGES];
  // Gray pixels give a zero hue divisor; both their quotients are dropped.
  assign hsv_o.hue        = gray[STAGES] ? '0 : h_quo[STAGES];
  assign hsv_o.saturation = gray[STAGES] ? '0 : s_quo[STAGES];
  assign hsv_o.brightness = bright[STAGES];

endmodule

// ----- design/r2h_front.sv -----
// Front stage: max, min, delta, hue numerator and divisor, and the saturation halves, registered.
module r2h_front
  import r2h_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned HUE_BITS     = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [CHANNEL_BITS-1:0]                red_i,
  input  logic [CHANNEL_BITS-1:0]                green_i,
  input  logic [CHANNEL_BITS-1:0]                blue_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   gray_o,
  output logic [CHANNEL_BITS-1:0]                bright_o,
  output logic [CHANNEL_BITS+DIV_EXTRA_BITS-1:0] hue_rem_o,
  output logic [CHANNEL_BITS+DIV_EXTRA_BITS-1:0] hue_div_o,
  output logic [HUE_BITS-1:0]                    hue_quo_o,
  output logic [CHANNEL_BITS-1:0]                sat_rem_o,
  output logic [CHANNEL_BITS-1:0]                sat_low_o,
  output logic [CHANNEL_BITS-1:0]                sat_quo_o
);

  localparam int unsigned C  = CHANNEL_BITS;
  localparam int unsigned DW = CHANNEL_BITS + DIV_EXTRA_BITS;
  localparam int unsigned NW = DW + 1;

  r2h_max_e                 max_sel;
  logic [C-1:0]             mx, mn, delta;
  logic [C-1:0]             dif_a, dif_b;
  logic [DW-1:0]            div6;
  logic signed [NW-1:0]     offs, diff, num_raw, num_wrap;

  logic                     valid_q;
  logic                     gray_q;
  logic [C-1:0]             bright_q, sat_rem_q, sat_low_q;
  logic [DW-1:0]            hue_rem_q, hue_div_q;
  logic                     ready;

  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      max_sel = MAX_RED;
    end else if (green_i >= blue_i) begin
      max_sel = MAX_GREEN;
    end else begin
      max_sel = MAX_BLUE;
    end

    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;

    unique case (max_sel)
      MAX_RED: begin
        mx    = red_i;
        dif_a = green_i;
        dif_b = blue_i;
      end
      MAX_GREEN: begin
        mx    = green_i;
        dif_a = blue_i;
        dif_b = red_i;
      end
      MAX_BLUE: begin
        mx    = blue_i;
        dif_a = red_i;
        dif_b = green_i;
      end
      default: begin
        mx    = red_i;
        dif_a = green_i;
        dif_b = blue_i;
      end
    endcase

    delta = mx - mn;
    div6  = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};

    unique case (max_sel)
      MAX_RED:   offs = '0;
      MAX_GREEN: offs = $signed({3'b000, delta, 1'b0});
      MAX_BLUE:  offs = $signed({2'b00, delta, 2'b00});
      default:   offs = '0;
    endcase

    diff     = $signed({4'b0000, dif_a}) - $signed({4'b0000, dif_b});
    num_raw  = offs + diff;
    // A negative numerator wraps by one full turn, six times delta.
    num_wrap = num_raw[NW-1] ? (num_raw + $signed({1'b0, div6})) : num_raw;
  end

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  // Saturation divides (2^C - 1) * delta by max; its high half is delta - 1
  // and its low half is 2^C - delta.
  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      gray_q    <= (delta == '0);
      bright_q  <= mx;
      hue_rem_q <= num_wrap[DW-1:0];
      hue_div_q <= div6;
      sat_rem_q <= delta - C'(1);
      sat_low_q <= C'(0) - delta;
    end
  end

  assign out_valid_o = valid_q;
  assign gray_o      = gray_q;
  assign bright_o    = bright_q;
  assign hue_rem_o   = hue_rem_q;
  assign hue_div_o   = hue_div_q;
  assign hue_quo_o   = '0;
  assign sat_rem_o   = sat_rem_q;
  assign sat_low_o   = sat_low_q;
  assign sat_quo_o   = '0;

endmodule

// ----- design/r2h_div_cell.sv -----
// One cell of the divider chain: a restoring step for hue, saturation or both, as DO_HUE and DO_SAT select.
module r2h_div_cell
  import r2h_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned HUE_BITS     = 16,
  parameter bit          DO_HUE       = 1'b1,
  parameter bit          DO_SAT       = 1'b1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  input  logic                                   gray_i,
  input  logic [CHANNEL_BITS-1:0]                bright_i,
  input  logic [CHANNEL_BITS+DIV_EXTRA_BITS-1:0] hue_rem_i,
  input  logic [CHANNEL_BITS+DIV_EXTRA_BITS-1:0] hue_div_i,
  input  logic [HUE_BITS-1:0]                    hue_quo_i,
  input  logic [CHANNEL_BITS-1:0]                sat_rem_i,
  input  logic [CHANNEL_BITS-1:0]                sat_low_i,
  input  logic [CHANNEL_BITS-1:0]                sat_quo_i,
  output logic                                   gray_o,
  output logic [CHANNEL_BITS-1:0]                bright_o,
  output logic [CHANNEL_BITS+DIV_EXTRA_BITS-1:0] hue_rem_o,
  output logic [CHANNEL_BITS+DIV_EXTRA_BITS-1:0] hue_div_o,
  output logic [HUE_BITS-1:0]                    hue_quo_o,
  output logic [CHANNEL_BITS-1:0]                sat_rem_o,
  output logic [CHANNEL_BITS-1:0]                sat_low_o,
  output logic [CHANNEL_BITS-1:0]                sat_quo_o
);

  localparam int unsigned C  = CHANNEL_BITS;
  localparam int unsigned DW = CHANNEL_BITS + DIV_EXTRA_BITS;

  logic [DW:0]      hue_two;
  logic             hue_bit;
  logic [C:0]       sat_two;
  logic             sat_bit;
  logic [DW-1:0]    hue_rem_d;
  logic [HUE_BITS-1:0] hue_quo_d;
  logic [C-1:0]     sat_rem_d, sat_low_d, sat_quo_d;

  logic             valid_q;
  logic             gray_q;
  logic [C-1:0]     bright_q, sat_rem_q, sat_low_q, sat_quo_q;
  logic [DW-1:0]    hue_rem_q, hue_div_q;
  logic [HUE_BITS-1:0] hue_quo_q;
  logic             ready;

  // The remainder stays below the divisor, so doubling it needs one more bit
  // and a subtraction brings it back below the divisor.
  always_comb begin
    hue_two = {hue_rem_i, 1'b0};
    hue_bit = (hue_two >= {1'b0, hue_div_i});
    sat_two = {sat_rem_i, sat_low_i[C-1]};
    sat_bit = (sat_two >= {1'b0, bright_i});

    if (DO_HUE) begin
      hue_rem_d = hue_bit ? DW'(hue_two - {1'b0, hue_div_i}) : hue_two[DW-1:0];
      hue_quo_d = {hue_quo_i[HUE_BITS-2:0], hue_bit};
    end else begin
      hue_rem_d = hue_rem_i;
      hue_quo_d = hue_quo_i;
    end

    if (DO_SAT) begin
      sat_rem_d = sat_bit ? C'(sat_two - {1'b0, bright_i}) : sat_two[C-1:0];
      sat_low_d = {sat_low_i[C-2:0], 1'b0};
      sat_quo_d = {sat_quo_i[C-2:0], sat_bit};
    end else begin
      sat_rem_d = sat_rem_i;
      sat_low_d = sat_low_i;
      sat_quo_d = sat_quo_i;
    end
  end

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      gray_q    <= gray_i;
      bright_q  <= bright_i;
      hue_rem_q <= hue_rem_d;
      hue_div_q <= hue_div_i;
      hue_quo_q <= hue_quo_d;
      sat_rem_q <= sat_rem_d;
      sat_low_q <= sat_low_d;
      sat_quo_q <= sat_quo_d;
    end
  end

  assign out_valid_o = valid_q;
  assign gray_o      = gray_q;
  assign bright_o    = bright_q;
  assign hue_rem_o   = hue_rem_q;
  assign hue_div_o   = hue_div_q;
  assign hue_quo_o   = hue_quo_q;
  assign sat_rem_o   = sat_rem_q;
  assign sat_low_o   = sat_low_q;
  assign sat_quo_o   = sat_quo_q;

endmodule
